@@ rtl/aesp_pkg.sv @@
// ----------------------------------------------------------------------------
// aesp_pkg
// Types and constants shared by the escape/SGR parser.
// ----------------------------------------------------------------------------
package aesp_pkg;

	typedef enum logic [2:0] {
		PH_GROUND    = 3'd0,
		PH_ESC       = 3'd1,
		PH_ESC_INTER = 3'd2,
		PH_CSI_PARAM = 3'd3,
		PH_CSI_INTER = 3'd4,
		PH_STR       = 3'd5,
		PH_STR_ESC   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		CT_IDLE  = 3'd0,
		CT_READ  = 3'd1,
		CT_WALK  = 3'd2,
		CT_OUT   = 3'd3
	} ctl_t;

	typedef enum logic [2:0] {
		WM_CODE = 3'd0,
		WM_EXT  = 3'd1,
		WM_IDX  = 3'd2,
		WM_RGB  = 3'd3,
		WM_KIND = 3'd4
	} wmode_t;

	localparam logic [1:0] KIND_DEF = 2'd0;
	localparam logic [1:0] KIND_IDX = 2'd1;
	localparam logic [1:0] KIND_RGB = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_LBR = 8'h5b;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_M   = 8'h6d;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COLON = 8'h3a;

	typedef struct packed {
		logic        tv;
		logic [7:0]  tb;
		logic        se;
	} res_t;

endpackage

@@ rtl/aesp_if.sv @@
// ----------------------------------------------------------------------------
// aesp_if
// Valid/ready channel carrying one word of payload.
// ----------------------------------------------------------------------------
interface aesp_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ansi_escape_sgr_parser_core.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_sgr_parser_core
// Escape stripper with SGR color and attribute tracking.
// ----------------------------------------------------------------------------
// channel  dir  word
// in_ch    in   in_byte[7:0]
// out_ch   out  text_valid, text_byte, fg/bg kind+value, attr_bits, string_end
// cfg      in   cfg_we, cfg_wdata (italic_supported)
//
// Ordinary bytes are taken one per cycle; the input waits while an unaccepted word
// is held, unless that word leaves at the same edge. A final 'm' with arguments
// walks the argument memory one entry per cycle and the word shows when the
// walk ends; each 38/48 colon chain is counted first and then walked again
// from its 38/48 entry. The walk is bound by the single read port. No clearing
// pass after reset.
// ----------------------------------------------------------------------------
module ansi_escape_sgr_parser_core
	import aesp_pkg::*;
#(
	parameter int MAX_ARGS  = 32,
	parameter int ARG_CLAMP = 9999
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	aesp_if.sink   in_ch,
	aesp_if.source out_ch
);

	localparam int AW = $clog2(MAX_ARGS);
	localparam int CW = $clog2(MAX_ARGS + 1);

	// argument memory: value and colon mark
	logic [14:0] mem [MAX_ARGS];
	logic [14:0] rd_s1;
	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [14:0] mem_wd;

	// last argument is written at the edge the walk reads entry 0
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= (mem_we && mem_wa == mem_ra) ? mem_wd : mem[mem_ra];
	end

	logic         ital_q;
	phase_t       ph_q, ph_d;
	ctl_t         ct_q, ct_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [13:0]  acc_q, acc_d;
	logic         closed_q, closed_d;
	logic [7:0]   fpb_q, fpb_d;
	logic         sep_q, sep_d;
	logic [25:0]  fg_q, fg_d, bg_q, bg_d;
	logic [6:0]   attr_q, attr_d;

	// walk registers
	logic [CW-1:0] wi_q, wi_d;          // index of entry arriving in rd_s1
	wmode_t       wm_q, wm_d;          // walk mode
	logic         wfg_q, wfg_d;
	logic [CW-1:0] wn_q, wn_d;          // args available for ext
	logic         wcol_q, wcol_d;
	logic [1:0]   wk_q, wk_d;          // rgb component count / skip
	logic         wskip_q, wskip_d;
	logic [23:0]  wrgb_q, wrgb_d;
	logic         wchain_q, wchain_d;  // counting colon chain
	logic [CW-1:0] wsub_q, wsub_d;

	logic  ov_q, ov_d;
	res_t  or_q, or_d;
	logic  out_load;
	logic  out_free;
	logic  wWRGB_en;

	assign out_free = !ov_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ital_q <= 1'b1;
		else if (cfg_we) ital_q <= cfg_wdata;
	end

	function automatic logic [7:0] sat8(input logic [13:0] v);
		return (v > 14'd255) ? 8'hff : v[7:0];
	endfunction

	// byte-side parse
	logic [7:0] c;
	logic       acc_ok;
	logic       start_walk;
	res_t       br;
	assign c = in_ch.data;
	assign in_ch.ready = (ct_q == CT_IDLE) && out_free;
	assign acc_ok = in_ch.valid && in_ch.ready;

	always_comb begin
		logic [17:0] v;
		logic        redo;
		logic        do_final, fin_walk;
		logic        do_coll;
		phase_t      p;
		ph_d = ph_q; cnt_d = cnt_q; acc_d = acc_q; closed_d = closed_q;
		fpb_d = fpb_q; sep_d = sep_q; fg_d = fg_q; bg_d = bg_q; attr_d = attr_q;
		mem_we = 1'b0; mem_wa = cnt_q[AW-1:0]; mem_wd = {1'b0, acc_q};
		br = '0; start_walk = 1'b0; do_final = 1'b0; fin_walk = 1'b0;
		do_coll = 1'b0; redo = 1'b0; p = ph_q; v = '0;
		// first pass
		case (ph_q)
			PH_ESC: begin
				if (c == CH_LBR) begin
					cnt_d = '0; acc_d = '0; closed_d = 1'b0; fpb_d = '0; sep_d = 1'b0;
					p = PH_CSI_PARAM;
				end else if (c == 8'h5d || c == 8'h50 || c == 8'h58 || c == 8'h5e
					|| c == 8'h5f) p = PH_STR;
				else if (c >= 8'h20 && c <= 8'h2f) p = PH_ESC_INTER;
				else if (c >= 8'h30 && c <= 8'h7e) p = PH_GROUND;
				else begin p = PH_GROUND; redo = 1'b1; end
			end
			PH_ESC_INTER: begin
				if (c >= 8'h20 && c <= 8'h2f) p = PH_ESC_INTER;
				else if (c >= 8'h30 && c <= 8'h7e) p = PH_GROUND;
				else begin p = PH_GROUND; redo = 1'b1; end
			end
			PH_CSI_PARAM: begin
				if (c >= 8'h30 && c <= 8'h3f) do_coll = 1'b1;
				else if (c >= 8'h20 && c <= 8'h2f) begin do_coll = 1'b1; p = PH_CSI_INTER; end
				else if (c >= 8'h40 && c <= 8'h7e) do_final = 1'b1;
				else begin p = PH_GROUND; redo = 1'b1; end
			end
			PH_CSI_INTER: begin
				if (c >= 8'h20 && c <= 8'h2f) do_coll = 1'b1;
				else if (c >= 8'h40 && c <= 8'h7e) do_final = 1'b1;
				else begin p = PH_GROUND; redo = 1'b1; end
			end
			PH_STR: begin
				if (c == CH_BEL) p = PH_GROUND;
				else if (c == CH_ESC) p = PH_STR_ESC;
				else if (c == CH_NUL) begin p = PH_GROUND; redo = 1'b1; end
			end
			PH_STR_ESC: begin
				if (c == CH_BSL) p = PH_GROUND;
				else begin
					p = PH_STR;
					if (c == CH_BEL) p = PH_GROUND;
					else if (c == CH_ESC) p = PH_STR_ESC;
					else if (c == CH_NUL) begin p = PH_GROUND; redo = 1'b1; end
				end
			end
			default: redo = 1'b1;
		endcase
		if (do_coll) begin
			if (fpb_q == 8'd0) fpb_d = c;
			if (!closed_q) begin
				if (c >= 8'h30 && c <= 8'h39) begin
					v = {4'd0, acc_q} * 18'd10 + {10'd0, c - 8'h30};
					acc_d = (v > 18'(ARG_CLAMP)) ? 14'(ARG_CLAMP) : v[13:0];
					sep_d = 1'b0;
				end else begin
					if (cnt_q < CW'(MAX_ARGS)) begin
						mem_we = 1'b1; mem_wd = {c == CH_COLON, acc_q};
						cnt_d = cnt_q + 1'b1; acc_d = '0;
						if (cnt_q + 1'b1 >= CW'(MAX_ARGS)) closed_d = 1'b1;
					end else closed_d = 1'b1;
					if (c == CH_SEMI || c == CH_COLON) sep_d = 1'b1;
					else begin closed_d = 1'b1; sep_d = 1'b0; end
				end
			end
		end
		if (do_final) begin
			p = PH_GROUND;
			if (c == CH_M) begin
				if (fpb_q == 8'd0) begin
					fg_d = '0; bg_d = '0; attr_d = '0;
				end else if (fpb_q < 8'h3c) begin
					fin_walk = 1'b1;
					if (!closed_q && !sep_q) begin
						if (cnt_q < CW'(MAX_ARGS)) begin
							mem_we = 1'b1; mem_wd = {1'b0, acc_q};
							cnt_d = cnt_q + 1'b1; acc_d = '0;
						end
						closed_d = 1'b1;
					end
				end
			end
		end
		if (redo) begin
			p = PH_GROUND;
			if (c == CH_NUL) begin
				br.se = 1'b1;
				cnt_d = '0; acc_d = '0; closed_d = 1'b0; fpb_d = '0; sep_d = 1'b0;
				fg_d = '0; bg_d = '0; attr_d = '0;
			end else if (c == CH_ESC) p = PH_ESC;
			else begin br.tv = 1'b1; br.tb = c; end
		end
		ph_d = p;
		start_walk = fin_walk && cnt_d != '0;
		if (!acc_ok) begin
			ph_d = ph_q; cnt_d = cnt_q; acc_d = acc_q; closed_d = closed_q;
			fpb_d = fpb_q; sep_d = sep_q; fg_d = fg_q; bg_d = bg_q; attr_d = attr_q;
			mem_we = 1'b0; start_walk = 1'b0;
		end
	end

	// walk sequencer: rd_s1 holds entry wi_q during CT_WALK
	logic [25:0] wfgo, wbgo;
	logic [6:0]  wattro;
	logic        wdone;
	always_comb begin
		logic [13:0] a;
		logic        cm;
		logic [CW-1:0] nxt;
		logic [CW-1:0] rem;
		logic [25:0] col;
		a = rd_s1[13:0]; cm = rd_s1[14];
		ct_d = ct_q; wi_d = wi_q; wm_d = wm_q; wfg_d = wfg_q; wn_d = wn_q;
		wcol_d = wcol_q; wk_d = wk_q; wskip_d = wskip_q; wrgb_d = wrgb_q;
		wchain_d = wchain_q; wsub_d = wsub_q;
		wfgo = fg_q; wbgo = bg_q; wattro = attr_q; wdone = 1'b0;
		nxt = wi_q + 1'b1; rem = cnt_q - wi_q - 1'b1;
		col = wfg_q ? fg_q : bg_q;
		mem_ra = '0;
		case (ct_q)
			CT_IDLE: begin
				if (start_walk) begin
					ct_d = CT_WALK; wi_d = '0; wm_d = WM_CODE; wchain_d = 1'b0;
				end
			end
			CT_WALK: begin
				if (wchain_q) begin
					// count colon chain starting at the 38/48 entry (wn_q start)
					if (cm && nxt < cnt_q) begin
						wsub_d = wsub_q + 1'b1; wi_d = nxt;
					end else begin
						wchain_d = 1'b0; wm_d = WM_EXT;
						if (wsub_q != '0) begin
							wn_d = wsub_q; wcol_d = 1'b1;
						end else begin
							wn_d = cnt_q - wn_q - 1'b1; wcol_d = 1'b0;
						end
						wi_d = wn_q; // restart from the 38/48 entry
					end
				end else begin
					case (wm_q)
						WM_CODE: begin
							if (a == 14'd0) begin wfgo = '0; wbgo = '0; wattro = '0; end
							else if (a == 14'd1) wattro[0] = 1'b1;
							else if (a == 14'd2) wattro[1] = 1'b1;
							else if (a == 14'd3 && ital_q) wattro[2] = 1'b1;
							else if (a == 14'd4) wattro[3] = 1'b1;
							else if (a == 14'd5 || a == 14'd6) wattro[4] = 1'b1;
							else if (a == 14'd7) wattro[5] = 1'b1;
							else if (a == 14'd8) wattro[6] = 1'b1;
							else if (a == 14'd22) wattro[1:0] = 2'b00;
							else if (a == 14'd23 && ital_q) wattro[2] = 1'b0;
							else if (a == 14'd24) wattro[3] = 1'b0;
							else if (a == 14'd25) wattro[4] = 1'b0;
							else if (a == 14'd27) wattro[5] = 1'b0;
							else if (a == 14'd28) wattro[6] = 1'b0;
							else if (a == 14'd38 || a == 14'd48) begin
								wfg_d = (a == 14'd38);
								wchain_d = 1'b1; wsub_d = '0; wn_d = wi_q;
								if (cm && nxt < cnt_q) wsub_d = CW'(1);
								else begin
									// next read is already the kind entry
									wchain_d = 1'b0; wn_d = rem; wcol_d = 1'b0;
									if (rem == '0) wm_d = WM_CODE;
									else wm_d = WM_KIND;
								end
							end
							else if (a == 14'd39) wfgo = '0;
							else if (a == 14'd49) wbgo = '0;
							else if (a >= 14'd30 && a <= 14'd37)
								wfgo = {KIND_IDX, 16'd0, a[7:0] - 8'd30};
							else if (a >= 14'd40 && a <= 14'd47)
								wbgo = {KIND_IDX, 16'd0, a[7:0] - 8'd40};
							else if (a >= 14'd90 && a <= 14'd97)
								wfgo = {KIND_IDX, 16'd0, a[7:0] - 8'd82};
							else if (a >= 14'd100 && a <= 14'd107)
								wbgo = {KIND_IDX, 16'd0, a[7:0] - 8'd92};
							wi_d = nxt;
						end
						WM_EXT: begin
							// wi_q is the 38/48 entry; next read gives the kind
							wi_d = nxt; wm_d = WM_KIND;
							if (wn_q == '0) wm_d = WM_CODE;
						end
						WM_KIND: begin
							// a = kind entry
							if (a == 14'd5) begin
								if (wn_q < CW'(2)) begin wi_d = wi_q + wn_q; wm_d = WM_CODE; end
								else begin wm_d = WM_IDX; wi_d = nxt; end
							end else if (a == 14'd2) begin
								wskip_d = wcol_q && wn_q >= CW'(5);
								if (wn_q < (wskip_d ? CW'(5) : CW'(4))) begin
									wi_d = wi_q + wn_q; wm_d = WM_CODE;
								end else begin
									wm_d = WM_RGB; wk_d = 2'd0; wi_d = nxt;
									if (wskip_d) wi_d = wi_q + CW'(2);
								end
							end else begin wi_d = nxt; wm_d = WM_CODE; end
						end
						WM_IDX: begin
							if (a < 14'd256) col = {KIND_IDX, 16'd0, a[7:0]};
							if (wfg_q) wfgo = col; else wbgo = col;
							wi_d = nxt; wm_d = WM_CODE;
						end
						WM_RGB: begin
							wrgb_d = {wrgb_q[15:0], sat8(a)};
							wk_d = wk_q + 1'b1; wi_d = nxt;
							if (wk_q == 2'd2) begin
								col = {KIND_RGB, wrgb_q[15:0], sat8(a)};
								if (wfg_q) wfgo = col; else wbgo = col;
								wm_d = WM_CODE;
							end
						end
						default: wm_d = WM_CODE;
					endcase
				end
				if (wi_d >= cnt_q && !wchain_d && !(wm_d == WM_EXT)) begin
					ct_d = CT_IDLE; wdone = 1'b1;
				end
			end
			default: ct_d = CT_IDLE;
		endcase
		mem_ra = (ct_d == CT_WALK) ? wi_d[AW-1:0] : '0;
		if (ct_q == CT_WALK && wchain_q && !wchain_d) mem_ra = wn_q[AW-1:0];
	end

	// output word: latched at byte time; walk updates color state afterwards
	assign out_load = acc_ok;
	always_comb begin
		or_d = br;
	end

	always_comb begin
		ov_d = ov_q;
		if (out_ch.valid && out_ch.ready) ov_d = 1'b0;
		if (out_load) ov_d = !start_walk;
		if (wdone) ov_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_GROUND; ct_q <= CT_IDLE; cnt_q <= '0; acc_q <= '0;
			closed_q <= 1'b0; fpb_q <= '0; sep_q <= 1'b0;
			fg_q <= '0; bg_q <= '0; attr_q <= '0;
			wi_q <= '0; wm_q <= WM_CODE; wfg_q <= 1'b0; wn_q <= '0; wcol_q <= 1'b0;
			wk_q <= '0; wskip_q <= 1'b0; wchain_q <= 1'b0; wsub_q <= '0;
			ov_q <= 1'b0;
		end else begin
			ph_q <= ph_d; ct_q <= ct_d; cnt_q <= cnt_d; acc_q <= acc_d;
			closed_q <= closed_d; fpb_q <= fpb_d; sep_q <= sep_d;
			wi_q <= wi_d; wm_q <= wm_d; wfg_q <= wfg_d; wn_q <= wn_d;
			wcol_q <= wcol_d; wk_q <= wk_d; wskip_q <= wskip_d;
			wchain_q <= wchain_d; wsub_q <= wsub_d;
			if (ct_q == CT_WALK) begin
				fg_q <= wfgo; bg_q <= wbgo; attr_q <= wattro;
			end else begin
				fg_q <= fg_d; bg_q <= bg_d; attr_q <= attr_d;
			end
			ov_q <= ov_d;
		end
	end

	assign wWRGB_en = (ct_q == CT_WALK);

	always_ff @(posedge clk) begin
		if (out_load) or_q <= or_d;
		if (wWRGB_en) wrgb_q <= wrgb_d;
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data = {or_q.tv, or_q.tb, fg_q[25:24], fg_q[23:0], bg_q[25:24],
		bg_q[23:0], attr_q, or_q.se};

`ifndef SYNTHESIS
	a_walk_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		ct_q == CT_WALK |-> !in_ch.ready)
		else $error("input taken during walk");
	a_no_out_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ct_q == CT_WALK |-> !ov_q)
		else $error("word shown during walk");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ARGS))
		else $error("argument count overflow");
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		wdone |=> ov_q && ct_q == CT_IDLE)
		else $error("walk end lost word");
`endif

endmodule
